// File: sv/block_bitmap_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Block bitmap allocator - assertion macros
// Shared property wrappers for the checker; clock is clk, reset is arst_n.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// Check a property on every rising clk edge outside reset.
`define BBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define BBA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Types and fixed constants of the block bitmap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bba_pkg;

	// Bitmap word geometry
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;

	// Field widths
	localparam int CFG_W = 11;
	localparam int BN_W  = 10;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} act_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_REJECT  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_MODIFY
	} fsm_t;

	// Status from the bitmap store to the controller
	typedef struct packed {
		logic clear_busy;
		logic nf_found;
	} map_stat_t;

endpackage

// File: sv/block_bitmap_allocator_unit.sv
// Flow: an accepted request reads its bitmap word, and the modify step writes
//   it back on success and loads the result register. Requests are taken one
//   at a time, set by the read-modify-write of one bitmap word; a stalled result
//   beat holds the write-back, and with it the next accept, until m_tready takes the beat.
// Reset: arst_n clears control state, sets the block limit to 1024 and starts a
//   sweep that zeroes the bitmap; s_tready rises in the cycle after the sweep ends,
//   while configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// First-fit block allocator over a word-wide bitmap memory. An allocate takes
// the lowest free block below the configured limit; a free clears a used block
// and rejects an out-of-range or already free block. Each beat in gives one
// beat out, carrying the status, the block taken and the free block count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_bitmap_allocator_unit
	import bba_pkg::*;
#(
	parameter int MAX_BLOCKS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	// Configuration: block limit
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	// Request stream
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // [9:0] block_number, [15:10] zero
	input  logic             s_tuser,   // [0] action
	// Result stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // [9:0] allocated_block, [20:10] free_count, [23:21] zero
	output logic [1:0]       m_tuser    // [1:0] status
);

	// Memory geometry: 32 blocks per word
	localparam int WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BLK_W = WA_W + BIT_W;
	localparam int CMP_W = (BLK_W > CFG_W) ? BLK_W : CFG_W;
	localparam int MX_W  = $clog2(MAX_BLOCKS + 1);
	localparam int LIM_W = (MX_W > CFG_W) ? MX_W : CFG_W;

	fsm_t              state_q;
	fsm_t              state_d;
	logic [CFG_W-1:0]  limit_cfg_q;
	logic [CFG_W-1:0]  used_cnt_q;

	// Request held across the read
	act_t              act_s1;
	logic [BN_W-1:0]   blk_s1;
	logic [WA_W-1:0]   addr_s1;
	logic              nf_found_s1;

	// Result register
	logic              m_tvalid_q;
	status_t           status_q;
	logic [BN_W-1:0]   alloc_blk_q;
	logic [CFG_W-1:0]  free_cnt_q;

	// Control
	logic              accept;
	logic              mod_go;

	// Bitmap store interface
	logic [WA_W-1:0]   rd_addr;
	logic [WORD_W-1:0] rd_word;
	logic              wr_en;
	logic [WORD_W-1:0] wr_word;
	logic [WA_W-1:0]   nf_addr;
	map_stat_t         map_stat;

	// Datapath
	logic [LIM_W-1:0]  lim_wide;
	logic [CFG_W-1:0]  lim;
	logic [CMP_W-1:0]  blk_word_w;
	logic [BIT_W-1:0]  zpos;
	logic [BIT_W-1:0]  pos;
	logic [WORD_W-1:0] bit_mask;
	logic [CMP_W-1:0]  cand_w;
	logic              alloc_ok;
	logic              free_ok;
	status_t           status_d;
	logic [BN_W-1:0]   alloc_blk_d;
	logic [CFG_W-1:0]  used_cnt_d;
	logic [CFG_W-1:0]  free_cnt_d;

	// ------------------------------------------------------------------
	// Configuration register: a limit above capacity acts as capacity
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			limit_cfg_q <= cfg_wdata;
		end
	end

	always_comb begin
		lim_wide = (LIM_W'(limit_cfg_q) > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS)
			: LIM_W'(limit_cfg_q);
		lim      = lim_wide[CFG_W-1:0];
	end

	// ------------------------------------------------------------------
	// Sequencer: CLEAR waits for the sweep, IDLE accepts and reads the
	// word, MODIFY waits until the result register is free, writes the
	// word back on success and loads the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_CLEAR: begin
				if (!map_stat.clear_busy) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (s_tvalid) begin
					state_d = FSM_MODIFY;
				end
			end
			FSM_MODIFY: begin
				// Hold until the result register can take the beat
				if (!m_tvalid_q || m_tready) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mod_go   = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
			end
			FSM_MODIFY: begin
				mod_go = !m_tvalid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Read address: an allocate reads the lowest word with a free bit,
	// a free reads the word that holds the named block
	// ------------------------------------------------------------------
	assign blk_word_w = CMP_W'(s_tdata[BN_W-1:0]) >> BIT_W;
	assign rd_addr    = (act_t'(s_tuser) == ACT_FREE) ? blk_word_w[WA_W-1:0] : nf_addr;

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1      <= act_t'(s_tuser);
			blk_s1      <= s_tdata[BN_W-1:0];
			addr_s1     <= rd_addr;
			nf_found_s1 <= map_stat.nf_found;
		end
	end

	bba_map #(
		.WORDS (WORDS),
		.WA_W  (WA_W)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (rd_word),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_word),
		.nf_addr (nf_addr),
		.stat    (map_stat)
	);

	// ------------------------------------------------------------------
	// Modify: first zero bit of the word for an allocate; the named bit
	// for a free
	// ------------------------------------------------------------------
	always_comb begin
		zpos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!rd_word[i]) begin
				zpos = BIT_W'(i);
			end
		end
	end

	always_comb begin
		pos      = (act_s1 == ACT_FREE) ? blk_s1[BIT_W-1:0] : zpos;
		bit_mask = WORD_W'(1) << pos;
		cand_w   = CMP_W'({addr_s1, zpos});
		// Lower words are all used, so the candidate is the first free block;
		// past the limit means no space
		alloc_ok = (act_s1 == ACT_ALLOC) && nf_found_s1 && (cand_w < CMP_W'(lim));
		free_ok  = (act_s1 == ACT_FREE) && ({1'b0, blk_s1} < lim) && rd_word[pos];
	end

	always_comb begin
		wr_en       = mod_go && (alloc_ok || free_ok);
		wr_word     = (act_s1 == ACT_FREE) ? (rd_word & ~bit_mask) : (rd_word | bit_mask);
		used_cnt_d  = used_cnt_q;
		alloc_blk_d = '0;
		if (alloc_ok) begin
			used_cnt_d  = used_cnt_q + 1'b1;
			alloc_blk_d = cand_w[BN_W-1:0];
		end else if (free_ok && (used_cnt_q != '0)) begin
			used_cnt_d = used_cnt_q - 1'b1;
		end
		if (alloc_ok || free_ok) begin
			status_d = ST_OK;
		end else if (act_s1 == ACT_ALLOC) begin
			status_d = ST_NOSPACE;
		end else begin
			status_d = ST_REJECT;
		end
		// Saturate at zero when the limit sits below the used count
		free_cnt_d = (lim > used_cnt_d) ? (lim - used_cnt_d) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_cnt_q <= '0;
		end else if (mod_go) begin
			used_cnt_q <= used_cnt_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register: drop valid once taken, load on every modify step, with or without a write-back
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (mod_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mod_go) begin
			status_q    <= status_d;
			alloc_blk_q <= alloc_blk_d;
			free_cnt_q  <= free_cnt_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, free_cnt_q, alloc_blk_q};

endmodule

// File: sv/bba_map.sv
// ----------------------------------------------------------------------------
// bba_map
// Word-wide bitmap memory with a summary of full words and a reset sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bba_map
	import bba_pkg::*;
#(
	parameter int WORDS = 32,
	parameter int WA_W  = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [WA_W-1:0]   rd_addr,
	output logic [WORD_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [WA_W-1:0]   wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WA_W-1:0]   nf_addr,
	output map_stat_t         stat
);

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORD_W-1:0] rd_data_q;
	logic [WORDS-1:0]  full_q;
	logic              clr_busy_q;
	logic [WA_W-1:0]   clr_addr_q;
	logic              nf_found;

	// Sweep the memory to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == WA_W'(WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Track which words have no free bit left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (wr_en && !clr_busy_q) begin
			full_q[wr_addr] <= &wr_data;
		end
	end

	// Lowest word that still holds a free bit
	always_comb begin
		nf_found = 1'b0;
		nf_addr  = '0;
		for (int i = WORDS - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				nf_found = 1'b1;
				nf_addr  = WA_W'(i);
			end
		end
	end

	assign rd_data         = rd_data_q;
	assign stat.clear_busy = clr_busy_q;
	assign stat.nf_found   = nf_found;

endmodule

// File: sv/bba_chk.sv
// ----------------------------------------------------------------------------
// bba_chk
// Port-level checks of the block bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_bitmap_allocator_unit_defines.svh"

module bba_chk
	import bba_pkg::*;
#(
	parameter int MAX_BLOCKS = 1024
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic out_stall;
	logic in_beat;
	logic status_known;
	logic count_ok;

	assign out_stall    = m_tvalid && !m_tready;
	assign in_beat      = s_tvalid && s_tready;
	assign status_known = (m_tuser == ST_OK) || (m_tuser == ST_NOSPACE)
		|| (m_tuser == ST_REJECT);
	assign count_ok     = (m_tdata[20:10] <= MAX_BLOCKS);

	// A beat waiting on the result side holds
	`BBA_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled beat changed")

	// Only one request at work: ready drops after each accepted beat
	`BBA_ASSERT(a_one_in_flight, in_beat |=> !s_tready, "request accepted while busy")

	// Block number is zero unless the request succeeded
	`BBA_ASSERT(a_blk_zero, m_tvalid && (m_tuser != ST_OK) |-> m_tdata[9:0] == 10'd0, "block set on failure")

	// Free count never exceeds capacity and the status code is known
	`BBA_ASSERT(a_free_range, m_tvalid |-> count_ok && status_known, "result out of range")

	// No result is offered once reset has been applied
	`BBA_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !m_tvalid, "result valid during reset")

endmodule

bind block_bitmap_allocator_unit bba_chk #(
	.MAX_BLOCKS (MAX_BLOCKS)
) u_bba_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
